### rtl/mpt_pkg.sv
// package for the missing packet tracker: widths, operation codes,
// control word layout and the microprogram table
// no dependencies
package mpt_pkg;

    localparam int MAX_PACKETS_DEF = 64;
    localparam int MAX_RESULTS     = 64;
    localparam int FUNC_W          = 2;
    localparam int PNUM_W          = 16;
    localparam int NUM_W           = 7;
    localparam int STEP_W          = 3;

    // operation codes on the func field
    localparam logic [FUNC_W-1:0] F_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] F_MARK   = 2'd1;
    localparam logic [FUNC_W-1:0] F_REPORT = 2'd2;

    // microprogram steps
    localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] S_CLR   = 3'd1;
    localparam logic [STEP_W-1:0] S_MARK  = 3'd2;
    localparam logic [STEP_W-1:0] S_SCAN  = 3'd3;
    localparam logic [STEP_W-1:0] S_CHECK = 3'd4;
    localparam logic [STEP_W-1:0] S_FIN   = 3'd5;

    // jump conditions
    localparam logic [2:0] J_NEXT     = 3'd0;
    localparam logic [2:0] J_GOTO     = 3'd1;
    localparam logic [2:0] J_DISPATCH = 3'd2;
    localparam logic [2:0] J_CLR_LOOP = 3'd3;
    localparam logic [2:0] J_SCAN_END = 3'd4;

    // write data select
    localparam logic WS_CLEAR = 1'b0;
    localparam logic WS_MARK  = 1'b1;

    typedef struct packed {
        logic              in_ready;
        logic              wr_en;
        logic              wr_sel;
        logic              idx_inc;
        logic              rd_en;
        logic              chk;
        logic              fin;
        logic [2:0]        jmp;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic              accept;
        logic [FUNC_W-1:0] func;
        logic              clr_done;
        logic              scan_end;
        logic              stall;
    } t_stat;

    function automatic t_ctrl mpt_rom(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = '0;
        unique case (step)
            S_IDLE: begin
                c.in_ready = 1'b1;
                c.jmp      = J_DISPATCH;
            end
            S_CLR: begin
                c.wr_en   = 1'b1;
                c.wr_sel  = WS_CLEAR;
                c.idx_inc = 1'b1;
                c.jmp     = J_CLR_LOOP;
                c.target  = S_IDLE;
            end
            S_MARK: begin
                c.wr_en  = 1'b1;
                c.wr_sel = WS_MARK;
                c.jmp    = J_GOTO;
                c.target = S_IDLE;
            end
            S_SCAN: begin
                c.rd_en  = 1'b1;
                c.jmp    = J_SCAN_END;
                c.target = S_FIN;
            end
            S_CHECK: begin
                c.chk     = 1'b1;
                c.idx_inc = 1'b1;
                c.jmp     = J_GOTO;
                c.target  = S_SCAN;
            end
            S_FIN: begin
                c.fin    = 1'b1;
                c.jmp    = J_GOTO;
                c.target = S_IDLE;
            end
            default: begin
                c.jmp    = J_GOTO;
                c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

### rtl/mpt_if.sv
// item channel interfaces for the missing packet tracker
// depends on mpt_pkg
interface mpt_in_if;
    import mpt_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [PNUM_W-1:0] packet_number;

    modport source  (output valid, func, packet_number, input ready);
    modport sink    (input valid, func, packet_number, output ready);
    modport monitor (input valid, ready, func, packet_number);
endinterface

interface mpt_out_if;
    import mpt_pkg::*;
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] missing_number;
    logic             has_number;
    logic [NUM_W-1:0] miss_total;
    logic             last;

    modport source  (output valid, missing_number, has_number, miss_total, last,
                     input ready);
    modport sink    (input valid, missing_number, has_number, miss_total, last,
                     output ready);
    modport monitor (input valid, ready, missing_number, has_number, miss_total,
                     last);
endinterface

### rtl/mpt_seq.sv
// microcode sequencer: step counter, program table lookup, jumps
// depends on mpt_pkg
module mpt_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mpt_pkg::t_stat i_stat,
    output mpt_pkg::t_ctrl o_ctrl
);
    import mpt_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             ctrl;

    assign ctrl   = mpt_rom(r_step);
    assign o_ctrl = ctrl;

    always_comb begin
        n_step = r_step;
        if (!i_stat.stall) begin
            unique case (ctrl.jmp)
                J_NEXT:     n_step = r_step + STEP_W'(1);
                J_GOTO:     n_step = ctrl.target;
                J_DISPATCH: begin
                    if (i_stat.accept) begin
                        unique case (i_stat.func)
                            F_CLEAR:  n_step = S_CLR;
                            F_MARK:   n_step = S_MARK;
                            F_REPORT: n_step = S_SCAN;
                            default:  n_step = S_IDLE;
                        endcase
                    end
                end
                J_CLR_LOOP: n_step = i_stat.clr_done ? ctrl.target : r_step;
                J_SCAN_END: n_step = i_stat.scan_end ? ctrl.target : r_step + STEP_W'(1);
                default:    n_step = S_IDLE;
            endcase
        end
    end

    // reset enters the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### rtl/mpt_datapath.sv
// datapath: received map memory, index and loss counters, pending result,
// output register and the packet total register
// depends on mpt_pkg and mpt_if
module mpt_datapath #(
    parameter int MAX_PACKETS = mpt_pkg::MAX_PACKETS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [mpt_pkg::NUM_W-1:0] i_cfg_data,
    input  mpt_pkg::t_ctrl          i_ctrl,
    output mpt_pkg::t_stat          o_stat,
    mpt_in_if.sink                  i_item,
    mpt_out_if.source               o_result
);
    import mpt_pkg::*;

    localparam int AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int IW = $clog2(MAX_PACKETS + 1);
    localparam int LW = (IW > NUM_W) ? IW : NUM_W;

    logic              mem [MAX_PACKETS];
    logic              r_rd;
    logic [IW-1:0]     r_idx;
    logic [NUM_W-1:0]  r_total;
    logic [PNUM_W-1:0] r_num;
    logic [NUM_W-1:0]  r_lost;
    logic [NUM_W-1:0]  r_pend;
    logic              r_pend_v;
    logic              r_ov;
    logic [NUM_W-1:0]  r_o_num;
    logic              r_o_has;
    logic [NUM_W-1:0]  r_o_cnt;
    logic              r_o_last;

    logic              accept;
    logic [LW-1:0]     total_x;
    logic [LW-1:0]     limit;
    logic [LW-1:0]     idx_x;
    logic [LW-1:0]     idx_p1;
    logic [PNUM_W-1:0] num_m1;
    logic              num_ok;
    logic              we;
    logic [AW-1:0]     wa;
    logic              miss;
    logic              take;
    logic              emit;
    logic              out_free;
    logic              stall;

    assign accept  = i_item.valid && i_ctrl.in_ready;
    assign total_x = LW'(r_total);
    assign limit   = (total_x > LW'(MAX_PACKETS)) ? LW'(MAX_PACKETS) : total_x;
    assign idx_x   = LW'(r_idx);
    assign idx_p1  = idx_x + LW'(1);
    assign num_m1  = r_num - PNUM_W'(1);
    assign num_ok  = (r_num != '0) && ({1'b0, r_num} <= (PNUM_W + 1)'(MAX_PACKETS));

    assign we = i_ctrl.wr_en && ((i_ctrl.wr_sel == WS_CLEAR) || num_ok);
    assign wa = (i_ctrl.wr_sel == WS_MARK) ? num_m1[AW-1:0] : r_idx[AW-1:0];

    // a missing entry is kept back until the next one shows it was not the last
    assign miss     = i_ctrl.chk && !r_rd;
    assign take     = miss && (r_lost < NUM_W'(MAX_RESULTS));
    assign emit     = (take && r_pend_v) || i_ctrl.fin;
    assign out_free = !r_ov || o_result.ready;
    assign stall    = emit && !out_free;

    assign o_stat.accept   = accept;
    assign o_stat.func     = i_item.func;
    assign o_stat.clr_done = (r_idx == IW'(MAX_PACKETS - 1));
    assign o_stat.scan_end = (idx_x == limit);
    assign o_stat.stall    = stall;

    assign i_item.ready            = i_ctrl.in_ready;
    assign o_result.valid          = r_ov;
    assign o_result.missing_number = r_o_num;
    assign o_result.has_number     = r_o_has;
    assign o_result.miss_total     = r_o_cnt;
    assign o_result.last           = r_o_last;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= (i_ctrl.wr_sel == WS_MARK);
        end
        if (i_ctrl.rd_en) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_num <= i_item.packet_number;
        end
        if (!stall && take) begin
            r_pend <= idx_p1[NUM_W-1:0];
        end
        if (emit && out_free) begin
            r_o_num  <= (i_ctrl.fin && !r_pend_v) ? '0 : r_pend;
            r_o_has  <= r_pend_v;
            r_o_cnt  <= i_ctrl.fin ? r_lost : '0;
            r_o_last <= i_ctrl.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_idx    <= '0;
            r_lost   <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
            if (accept) begin
                r_idx    <= '0;
                r_lost   <= '0;
                r_pend_v <= 1'b0;
            end else if (!stall) begin
                if (i_ctrl.idx_inc) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (miss) begin
                    r_lost <= r_lost + NUM_W'(1);
                end
                if (take) begin
                    r_pend_v <= 1'b1;
                end
            end
            if (emit && out_free) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

### rtl/missing_packet_tracker_unit.sv
// top level of the missing packet tracker: sequencer plus datapath
// depends on mpt_pkg, mpt_if, mpt_seq and mpt_datapath
//
//  channel    dir   payload                                      handshake
//  i_item     in    func, packet_number                          valid/ready
//  o_result   out   missing_number, has_number, miss_total, last valid/ready
//  i_cfg      in    packet_total on i_cfg_data                   i_cfg_we
//
// clear writes one map entry per cycle, over all MAX_PACKETS entries
// report reads min(packet_total, MAX_PACKETS) entries, with one memory read
// and one check per entry, then a closing read and the final result, and
// it waits while the output register is full
// after reset a clearing pass over all MAX_PACKETS entries runs with
// i_item.ready low; a stalled output holds the scan at the next result;
// config writes are taken in any cycle
module missing_packet_tracker_unit #(
    parameter int MAX_PACKETS = mpt_pkg::MAX_PACKETS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mpt_pkg::NUM_W-1:0] i_cfg_data,
    mpt_in_if.sink                    i_item,
    mpt_out_if.source                 o_result
);
    import mpt_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    mpt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    mpt_datapath #(
        .MAX_PACKETS (MAX_PACKETS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .i_item     (i_item),
        .o_result   (o_result)
    );

endmodule

### rtl/mpt_checker.sv
// port level checks for the missing packet tracker, bound to the top level
// depends on mpt_pkg and missing_packet_tracker_unit
module mpt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      i_ready,
    input logic [mpt_pkg::NUM_W-1:0] i_missing_number,
    input logic                      i_has_number,
    input logic [mpt_pkg::NUM_W-1:0] i_miss_total,
    input logic                      i_last
);
    import mpt_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=>
            i_valid && $stable(i_missing_number)
            && $stable(i_miss_total) && $stable(i_last)
            && $stable(i_has_number))
        else $error("result changed while stalled");

    // a result without a number is the lone empty report
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_has_number |->
            i_last && i_miss_total == '0 && i_missing_number == '0)
        else $error("result without number is not an empty report");

    // only the last result carries the count
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> i_has_number && i_miss_total == '0)
        else $error("non-last result carries a count");

    // packet numbers are 1-based
    a_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_has_number |-> i_missing_number != '0)
        else $error("missing number zero");

endmodule

bind missing_packet_tracker_unit mpt_checker u_mpt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_result.valid),
    .i_ready          (o_result.ready),
    .i_missing_number (o_result.missing_number),
    .i_has_number     (o_result.has_number),
    .i_miss_total     (o_result.miss_total),
    .i_last           (o_result.last)
);

### dv/tb_top.sv
// testbench for missing_packet_tracker_unit: directed and random clear/mark/report
// traffic, a scoreboard of expected missing-packet results, random sender/receiver idling
// depends on rtl/mpt_pkg.sv, rtl/mpt_if.sv and the tracker rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mpt_pkg::*;

    localparam int MAX_PACKETS   = MAX_PACKETS_DEF;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 420;
    localparam int RUN_LIMIT_NS  = 20_000_000;

    // func code the block has no operation for
    localparam logic [FUNC_W-1:0] F_UNUSED = 2'd3;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        logic [NUM_W-1:0] missing_number;
        logic             has_number;
        logic [NUM_W-1:0] miss_total;
        logic             last;
    } t_miss_rec;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             cfg_we   = 1'b0;
    logic [NUM_W-1:0] cfg_data = '0;

    mpt_in_if  item_if ();
    mpt_out_if result_if ();

    // predictor state
    logic [MAX_PACKETS-1:0] rx_map    = '0;
    logic [NUM_W-1:0]       total_reg = '0;
    t_miss_rec              missing_q[$];

    int mismatch_cnt  = 0;
    int burst_left    = 0;
    int tracked_items = 0;
    bit hold_req      = 1'b0;

    missing_packet_tracker_unit #(
        .MAX_PACKETS(MAX_PACKETS)
    ) DUT (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .i_item    (item_if),
        .o_result  (result_if)
    );

    always #5 clk = ~clk;

    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // update the map and queue the results one accepted item causes
    function automatic void apply_tracker_op(input logic [FUNC_W-1:0] f,
                                             input logic [PNUM_W-1:0] n);
        int        scan_len;
        int        lost;
        t_miss_rec rec;
        scan_len = (total_reg > MAX_PACKETS) ? MAX_PACKETS : int'(total_reg);
        lost = 0;
        case (f)
            F_CLEAR: rx_map = '0;
            F_MARK: begin
                if (n >= 1 && n <= MAX_PACKETS) rx_map[n - 1] = 1'b1;
            end
            F_REPORT: begin
                for (int i = 0; i < scan_len; i++) begin
                    if (!rx_map[i]) begin
                        rec = '{missing_number: NUM_W'(i + 1), has_number: 1'b1,
                                miss_total: '0, last: 1'b0};
                        missing_q.push_back(rec);
                        lost++;
                    end
                end
                if (lost == 0) begin
                    rec = '{missing_number: '0, has_number: 1'b0, miss_total: '0, last: 1'b1};
                end else begin
                    rec = missing_q.pop_back();
                    rec.miss_total = NUM_W'(lost);
                    rec.last = 1'b1;
                end
                missing_q.push_back(rec);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string fname, input logic [NUM_W-1:0] want,
                                        input logic [NUM_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        t_miss_rec want;
        if (rst_n && result_if.valid && result_if.ready) begin
            if (missing_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s=%0d has=%0d cnt=%0d last=%0d",
                         $time, "actual num", result_if.missing_number,
                         result_if.has_number, result_if.miss_total, result_if.last);
                mismatch_cnt++;
            end else begin
                want = missing_q.pop_front();
                check_field("missing_number", want.missing_number, result_if.missing_number);
                check_field("has_number", want.has_number, result_if.has_number);
                check_field("miss_total", want.miss_total, result_if.miss_total);
                check_field("last", want.last, result_if.last);
            end
        end
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    initial begin : rx_stall_gen
        t_rx_mode mode;
        int       mode_left;
        int       phase;
        mode = RX_OPEN;
        mode_left = 0;
        phase = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_OPEN:  result_if.ready <= 1'b1;
                    RX_LIGHT: result_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: result_if.ready <= ($urandom_range(0, 3) == 0);
                    default:  result_if.ready <= (phase % 5 != 0);
                endcase
            end
        end
    end

    // offer one item in the current burst and wait until it is taken
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [PNUM_W-1:0] n);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_if.valid         <= 1'b1;
        item_if.func          <= f;
        item_if.packet_number <= n;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        apply_tracker_op(f, n);
    endtask

    // all results in, then let a clear or report still running finish
    task automatic wait_tracker_idle();
        item_if.valid <= 1'b0;
        while (missing_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_total(input logic [NUM_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        total_reg = v;
    endtask

    task automatic test_empty_map_reports();
        send_item(F_REPORT, '0);
        wait_tracker_idle();
        write_total('1);
        send_item(F_REPORT, '1);
    endtask

    task automatic test_mark_filtering();
        send_item(F_MARK, 16'd0);
        send_item(F_MARK, 16'd1);
        send_item(F_MARK, PNUM_W'(MAX_PACKETS));
        send_item(F_MARK, PNUM_W'(MAX_PACKETS + 1));
        send_item(F_MARK, 16'hFFFF);
        send_item(F_UNUSED, 16'h5555);
        send_item(F_REPORT, 16'hAAAA);
        wait_tracker_idle();
        write_total(7'd2);
        send_item(F_REPORT, '0);
        send_item(F_MARK, 16'd2);
        send_item(F_REPORT, '0);
    endtask

    task automatic test_clear_and_retotal();
        send_item(F_CLEAR, 16'd7);
        send_item(F_REPORT, '0);
        wait_tracker_idle();
        write_total(NUM_W'(MAX_PACKETS));
        send_item(F_MARK, 16'd33);
        send_item(F_REPORT, '0);
    endtask

    // download sessions: set a total, clear, mark packets, report, with noise mixed in
    task automatic test_random_sessions();
        int               n_ops;
        int               pick;
        int               cap;
        logic [NUM_W-1:0] tot;
        while (tracked_items < RANDOM_ITEMS) begin
            wait_tracker_idle();
            case ($urandom_range(0, 7))
                0:       tot = '0;
                1:       tot = NUM_W'(MAX_PACKETS);
                2:       tot = '1;
                3:       tot = NUM_W'($urandom_range(MAX_PACKETS + 1, 127));
                4:       tot = NUM_W'($urandom_range(1, 8));
                default: tot = NUM_W'($urandom_range(1, MAX_PACKETS));
            endcase
            write_total(tot);
            cap = (tot == 0 || tot > MAX_PACKETS) ? MAX_PACKETS : int'(tot);
            if ($urandom_range(0, 4) != 0) begin
                send_item(F_CLEAR, PNUM_W'($urandom));
                tracked_items++;
            end
            n_ops = $urandom_range(15, 45);
            repeat (n_ops) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    send_item(F_MARK, PNUM_W'($urandom_range(1, cap)));
                    tracked_items++;
                end else if (pick < 72) begin
                    send_item(F_MARK, PNUM_W'($urandom_range(1, MAX_PACKETS)));
                    tracked_items++;
                end else if (pick < 80) begin
                    if ($urandom_range(0, 1) == 0) send_item(F_MARK, '0);
                    else send_item(F_MARK, PNUM_W'($urandom_range(MAX_PACKETS + 1, 65535)));
                    tracked_items++;
                end else if (pick < 88) begin
                    send_item(F_REPORT, PNUM_W'($urandom));
                    tracked_items++;
                end else if (pick < 91) begin
                    send_item(F_CLEAR, PNUM_W'($urandom));
                    tracked_items++;
                end else if (pick < 95) begin
                    send_item(F_UNUSED, PNUM_W'($urandom));
                    tracked_items++;
                end else begin
                    send_item(F_MARK, PNUM_W'($urandom));
                    tracked_items++;
                end
            end
            send_item(F_REPORT, PNUM_W'($urandom));
            tracked_items++;
        end
    endtask

    // long receiver hold-off during a full report so the input backs up
    task automatic test_output_holdoff();
        wait_tracker_idle();
        write_total(NUM_W'(MAX_PACKETS));
        send_item(F_CLEAR, '0);
        hold_req = 1'b1;
        send_item(F_REPORT, '0);
        for (int k = 0; k < 24; k++) begin
            if (k % 8 == 7) send_item(F_REPORT, PNUM_W'($urandom));
            else send_item(F_MARK, PNUM_W'($urandom_range(1, MAX_PACKETS)));
        end
    endtask

    initial begin : test_seq
        item_if.valid         <= 1'b0;
        item_if.func          <= F_CLEAR;
        item_if.packet_number <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_map_reports();
        test_mark_filtering();
        test_clear_and_retotal();
        test_random_sessions();
        test_output_holdoff();
        wait_tracker_idle();
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
